[sv/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define MEU_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define MEU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define MEU_ASSERT_IMPL(lbl, ante, cons, msg)

`define MEU_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

[sv/meu_pkg.sv]
// ---------------------------------------------------------------------------
// meu_pkg
// Types and constants of the exception entry unit.
// ---------------------------------------------------------------------------
package meu_pkg;

  localparam int unsigned IRQ_W  = 25;
  localparam int unsigned CODE_W = 5;
  localparam int unsigned COP_W  = 2;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [1:0] REQ_RAISE = 2'd0;
  localparam logic [1:0] REQ_POLL  = 2'd1;
  localparam logic [1:0] REQ_WRITE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_IRQ_EN   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IRQ_MASK = 1'b1;

  localparam logic [31:0] VEC_NORMAL = 32'h8000_0080;
  localparam logic [31:0] VEC_BOOT   = 32'hBFC0_0180;
  localparam logic [31:0] SLOT_BACK  = 32'h0000_0004;
  localparam int unsigned BEV_BIT    = 22;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [CODE_W-1:0] exc_code;
    logic [COP_W-1:0]  cop_num;
    logic [31:0]       cur_pc;
    logic              cur_in_delay;
    logic              cur_taken;
    logic [31:0]       next_pc;
    logic              next_in_delay;
    logic              next_taken;
    logic [IRQ_W-1:0]  irq_lines;
    logic [31:0]       write_word;
  } in_word_t;

  typedef struct packed {
    logic        jump_valid;
    logic [31:0] jump_target;
    logic [31:0] epc_out;
    logic [31:0] status_out;
    logic [31:0] cause_out;
    logic [31:0] target_addr_out;
  } out_word_t;

endpackage

[sv/meu_stream_if.sv]
// ---------------------------------------------------------------------------
// meu_stream_if
// Valid/ready channels for request and result words.
// ---------------------------------------------------------------------------
interface meu_in_if;
  logic              valid;
  logic              ready;
  meu_pkg::in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface meu_out_if;
  logic               valid;
  logic               ready;
  meu_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[sv/mips_exception_entry_unit.sv]
// ---------------------------------------------------------------------------
// mips_exception_entry_unit
// Coprocessor-0 exception entry: raise, interrupt poll and status write.
// ---------------------------------------------------------------------------
// One word is accepted per clock while the sink keeps up, and each word
// yields exactly one result word. Request words land in an input register;
// the cop0 state update and result formatting happen in one pass into the
// result register. With both registers, a new request is still taken while
// a finished result waits for out_ch.ready; throughput drops only when both
// are full and the sink stalls.
`include "assert_macros.svh"

module mips_exception_entry_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  meu_in_if.sink                            in_ch,
  meu_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [meu_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [meu_pkg::IRQ_W-1:0]         cfg_wdata
);

  logic                        irq_en_r;
  logic [meu_pkg::IRQ_W-1:0]   irq_mask_r;

  logic                        in_valid_r;
  meu_pkg::in_word_t           in_r;
  logic                        out_valid_r;
  meu_pkg::out_word_t          out_r, out_nxt;
  logic                        advance;

  logic [31:0]                 status_r, status_nxt;
  logic [meu_pkg::CODE_W-1:0]  code_r, code_nxt;
  logic [meu_pkg::COP_W-1:0]   cop_r, cop_nxt;
  logic                        bd_r, bd_nxt;
  logic                        bt_r, bt_nxt;
  logic                        ip2_r, ip2_nxt;
  logic [31:0]                 epc_r, epc_nxt;
  logic [31:0]                 tar_r, tar_nxt;

  logic                        take;
  logic [meu_pkg::CODE_W-1:0]  take_code;
  logic [meu_pkg::COP_W-1:0]   take_cop;
  logic                        pend;
  logic                        slot;
  logic                        slot_taken;
  logic [31:0]                 epc_base;

  assign advance      = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !in_valid_r || advance;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      irq_en_r   <= 1'b0;
      irq_mask_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        meu_pkg::CFG_IRQ_EN:   irq_en_r   <= cfg_wdata[0];
        meu_pkg::CFG_IRQ_MASK: irq_mask_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_r <= in_ch.data;
    end
  end

  always_comb begin
    pend       = irq_en_r && ((in_r.irq_lines & irq_mask_r) != '0);
    take       = 1'b0;
    take_code  = in_r.exc_code;
    take_cop   = in_r.cop_num;
    ip2_nxt    = ip2_r;
    status_nxt = status_r;
    case (in_r.req_type)
      meu_pkg::REQ_RAISE: begin
        take = 1'b1;
      end
      meu_pkg::REQ_POLL: begin
        ip2_nxt   = pend;
        take      = pend && status_r[0] && status_r[10];
        take_code = '0;
        take_cop  = '0;
      end
      meu_pkg::REQ_WRITE: begin
        status_nxt = in_r.write_word;
      end
      default: ;
    endcase

    if (take_code == '0) begin
      epc_base   = in_r.next_pc;
      slot       = in_r.next_in_delay;
      slot_taken = in_r.next_taken;
    end else begin
      epc_base   = in_r.cur_pc;
      slot       = in_r.cur_in_delay;
      slot_taken = in_r.cur_taken;
    end

    code_nxt = code_r;
    cop_nxt  = cop_r;
    bd_nxt   = bd_r;
    bt_nxt   = bt_r;
    epc_nxt  = epc_r;
    tar_nxt  = tar_r;
    if (take) begin
      status_nxt = {status_r[31:6], status_r[3:0], 2'b00};
      code_nxt   = take_code;
      cop_nxt    = take_cop;
      bd_nxt     = slot;
      bt_nxt     = slot && slot_taken;
      epc_nxt    = slot ? (epc_base - meu_pkg::SLOT_BACK) : epc_base;
      if (slot) begin
        tar_nxt = in_r.next_pc;
      end
    end

    out_nxt.jump_valid      = take;
    out_nxt.jump_target     = !take ? 32'd0 :
                              (status_nxt[meu_pkg::BEV_BIT] ? meu_pkg::VEC_BOOT
                                                            : meu_pkg::VEC_NORMAL);
    out_nxt.epc_out         = epc_nxt;
    out_nxt.status_out      = status_nxt;
    out_nxt.cause_out       = {bd_nxt, bt_nxt, cop_nxt, 12'd0, 5'd0, ip2_nxt, 2'd0,
                               1'b0, code_nxt, 2'b00};
    out_nxt.target_addr_out = tar_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r    <= '0;
      code_r      <= '0;
      cop_r       <= '0;
      bd_r        <= 1'b0;
      bt_r        <= 1'b0;
      ip2_r       <= 1'b0;
      epc_r       <= '0;
      tar_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        status_r <= status_nxt;
        code_r   <= code_nxt;
        cop_r    <= cop_nxt;
        bd_r     <= bd_nxt;
        bt_r     <= bt_nxt;
        ip2_r    <= ip2_nxt;
        epc_r    <= epc_nxt;
        tar_r    <= tar_nxt;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= out_nxt;
    end
  end

  `MEU_ASSERT_IMPL(a_vector, out_valid_r && out_r.jump_valid, out_r.jump_target == meu_pkg::VEC_NORMAL || out_r.jump_target == meu_pkg::VEC_BOOT, "jump target not a vector")
  `MEU_ASSERT_IMPL(a_no_jump_zero, out_valid_r && !out_r.jump_valid, out_r.jump_target == 32'd0, "target set without jump")
  `MEU_ASSERT_IMPL(a_entry_kernel, out_valid_r && out_r.jump_valid, out_r.status_out[1:0] == 2'b00, "entry left IEc/KUc set")
  `MEU_ASSERT_IMPL(a_ip_only_bit2, out_valid_r, (out_r.cause_out[15:8] & 8'hFB) == 8'h00, "stray pending bits")
  `MEU_ASSERT_NEXT(a_drain, in_valid_r && !out_valid_r, out_valid_r, "queued word not advanced")

endmodule
